// ===== design/rcfd_pkg.sv =====
// Shared types and constants for the remote-control frame decoder.
// Used by the register block, the frame store, the unpacker and the top level.
`default_nettype none

package rcfd_pkg;

    localparam int FRAME_BYTES = 21;
    localparam int POS_W       = 5;

    // Last byte position of each frame format.
    localparam logic [POS_W-1:0] RX_LAST_POS = POS_W'(17);
    localparam logic [POS_W-1:0] VL_LAST_POS = POS_W'(20);

    // Frame format codes.
    localparam logic FMT_RECEIVER = 1'b0;
    localparam logic FMT_LINK     = 1'b1;

    // Register index decoded from the APB address.
    localparam logic REG_DEADBAND    = 1'b0;
    localparam logic REG_STICK_LIMIT = 1'b1;

    localparam int CFG_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int OUT_DATA_W  = 152;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [5:0] deadband;
        logic [9:0] stick_limit;
    } cfg_t;

    typedef struct packed {
        logic             last;
        logic             fmt;
        logic [POS_W-1:0] pos;
    } frame_status_t;

    typedef struct packed {
        logic [5:0]         link_controls;
        logic [3:0]         lever_switches;
        logic [15:0]        key_bitmap;
        logic [15:0]        mouse_buttons;
        logic signed [15:0] mouse_z;
        logic signed [15:0] mouse_y;
        logic signed [15:0] mouse_x;
        logic signed [11:0] wheel;
        logic signed [10:0] stick_four;
        logic signed [10:0] stick_three;
        logic signed [10:0] stick_two;
        logic signed [10:0] stick_one;
    } result_t;

endpackage

`default_nettype wire

// ===== design/rcfd_cfg_regs.sv =====
// APB register block for the remote-control frame decoder: deadband and stick limit.
// Depends on rcfd_pkg for the register index codes and the cfg_t type.
`default_nettype none

module rcfd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rcfd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [rcfd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [rcfd_pkg::APB_DATA_W-1:0]  prdata,
    output rcfd_pkg::cfg_t                        cfg
);
    import rcfd_pkg::*;

    logic [5:0] deadband_reg;
    logic [9:0] stick_limit_reg;
    logic       wr_en;
    logic       reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= 6'd5;
            stick_limit_reg <= 10'd660;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DEADBAND:    deadband_reg    <= pwdata[5:0];
                REG_STICK_LIMIT: stick_limit_reg <= pwdata[9:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DEADBAND:    prdata = {26'd0, deadband_reg};
            REG_STICK_LIMIT: prdata = {22'd0, stick_limit_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.deadband    = deadband_reg;
    assign cfg.stick_limit = stick_limit_reg;

endmodule

`default_nettype wire

// ===== design/rcfd_frame_store.sv =====
// Byte position tracking and the 21-byte frame store of the frame decoder.
// Depends on rcfd_pkg; presents the frame as it stands including the byte being accepted.
`default_nettype none

module rcfd_frame_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [7:0]        data_byte,
    input  wire logic              frame_start,
    input  wire logic              link_format,
    output rcfd_pkg::frame_t       frame,
    output rcfd_pkg::frame_status_t status
);
    import rcfd_pkg::*;

    logic [7:0]       store_reg [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             fmt_reg;
    logic             fmt_next;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] wr_pos;
    logic             is_last;

    assign fmt_next  = frame_start ? link_format : fmt_reg;
    assign start_pos = frame_start ? '0 : pos_reg;
    assign last_pos  = (fmt_next == FMT_LINK) ? VL_LAST_POS : RX_LAST_POS;
    // A position past the end of the current format restarts the frame.
    assign wr_pos    = (start_pos > last_pos) ? '0 : start_pos;
    assign is_last   = (wr_pos == last_pos);
    assign pos_next  = is_last ? '0 : wr_pos + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fmt_reg <= FMT_RECEIVER;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            fmt_reg <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (fire && (wr_pos == POS_W'(i)))
            begin
                store_reg[i] <= data_byte;
            end
        end
    end

    // The incoming byte overlays its position so the last byte decodes without a bubble.
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame[i] = (wr_pos == POS_W'(i)) ? data_byte : store_reg[i];
        end
    end

    assign status.last = is_last;
    assign status.fmt  = fmt_next;
    assign status.pos  = pos_reg;

endmodule

`default_nettype wire

// ===== design/rcfd_unpack.sv =====
// Combinational unpacking of a complete frame into stick, wheel, mouse and key fields.
// Depends on rcfd_pkg for the frame, configuration and result types.
`default_nettype none

module rcfd_unpack (
    input  wire rcfd_pkg::frame_t frame,
    input  wire logic             fmt,
    input  wire rcfd_pkg::cfg_t   cfg,
    output rcfd_pkg::result_t     result
);
    import rcfd_pkg::*;

    // Raw 11-bit channel minus 1024 is the raw value with its top bit inverted.
    function automatic logic signed [10:0] centre(input logic [10:0] raw);
        return {~raw[10], raw[9:0]};
    endfunction

    function automatic logic [10:0] mag11(input logic signed [10:0] v);
        return v[10] ? 11'(-v) : 11'(v);
    endfunction

    logic [10:0]        raw [4];
    logic signed [10:0] ctr [4];
    logic signed [10:0] stk [4];
    logic [10:0]        stk_mag [4];
    logic [3:0]         over;
    logic [10:0]        wheel_raw;
    logic signed [10:0] wheel_ctr;
    logic signed [11:0] wheel_neg;
    logic [11:0]        wheel_mag;
    logic signed [11:0] wheel_val;
    result_t            dec;

    always_comb
    begin
        if (fmt == FMT_RECEIVER)
        begin
            raw[0] = {frame[1][2:0], frame[0]};
            raw[1] = {frame[2][5:0], frame[1][7:3]};
            raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
            raw[3] = {frame[5][3:0], frame[4][7:1]};
        end
        else
        begin
            raw[0] = {frame[3][2:0], frame[2]};
            raw[1] = {frame[4][5:0], frame[3][7:3]};
            raw[2] = {frame[7][3:0], frame[6][7:1]};
            raw[3] = {frame[6][0], frame[5], frame[4][7:6]};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ctr[k]     = centre(raw[k]);
            stk_mag[k] = mag11(ctr[k]);
            stk[k]     = (stk_mag[k] <= {5'd0, cfg.deadband}) ? '0 : ctr[k];
            over[k]    = (stk[k] != '0) && (stk_mag[k] > {1'b0, cfg.stick_limit});
        end
    end

    // The video-link wheel runs the other way and is deadbanded.
    assign wheel_raw = {frame[9][3:0], frame[8][7:1]};
    assign wheel_ctr = centre(wheel_raw);
    assign wheel_neg = -{wheel_ctr[10], wheel_ctr};
    assign wheel_mag = wheel_neg[11] ? 12'(-wheel_neg) : 12'(wheel_neg);

    always_comb
    begin
        dec = '0;
        dec.stick_one   = stk[0];
        dec.stick_two   = stk[1];
        dec.stick_three = stk[2];
        dec.stick_four  = stk[3];
        if (fmt == FMT_RECEIVER)
        begin
            wheel_val          = 12'(centre({frame[17][2:0], frame[16]}));
            dec.wheel          = wheel_val;
            dec.mouse_x        = {frame[7], frame[6]};
            dec.mouse_y        = {frame[9], frame[8]};
            dec.mouse_z        = {frame[11], frame[10]};
            dec.mouse_buttons  = {frame[13], frame[12]};
            dec.key_bitmap     = {frame[15], frame[14]};
            dec.lever_switches = {frame[5][5:4], frame[5][7:6]};
        end
        else
        begin
            wheel_val          = (wheel_mag <= {6'd0, cfg.deadband}) ? '0 : wheel_neg;
            dec.wheel          = wheel_val;
            dec.mouse_x        = {frame[11], frame[10]};
            dec.mouse_y        = {frame[13], frame[12]};
            dec.mouse_z        = {frame[15], frame[14]};
            dec.mouse_buttons  = {10'd0, frame[16][5:0]};
            dec.key_bitmap     = {frame[18], frame[17]};
            dec.link_controls  = {frame[9][4], frame[8][0], frame[7][7], frame[7][6],
                                  frame[7][5:4]};
        end
    end

    // Any stick beyond the limit voids the whole frame.
    assign result = (over != '0) ? '0 : dec;

endmodule

`default_nettype wire

// ===== design/remote_control_frame_decoder.sv =====
// Remote-control frame decoder top level: stream ports, result register and APB port.
// Instantiates rcfd_cfg_regs, rcfd_frame_store and rcfd_unpack; depends on rcfd_pkg.

// One frame byte is taken per cycle on the slave stream. A frame is 18 bytes in the
// receiver format or 21 bytes in the video-link format, chosen by tuser bit 1 on the byte
// that carries tuser bit 0 (frame start); a start byte always restarts the frame. The
// result is unpacked in the same cycle the last byte is accepted and appears on the master
// stream on the next cycle from a single result register, so frames decode at the full
// byte rate. The slave side stalls only while that register holds a result that has not
// been transferred. A frame with any stick beyond the limit still yields a result, all zero.
// Registers: deadband at byte address 0 (reset 5), stick limit at address 4 (reset 660).
`default_nettype none

module remote_control_frame_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]   s_axis_tuser,   // [0] frame_start, [1] link_format
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [10:0] stick_one, [21:11] stick_two, [32:22] stick_three, [43:33] stick_four,
    // [55:44] wheel, [71:56] mouse_x, [87:72] mouse_y, [103:88] mouse_z,
    // [119:104] mouse_buttons, [135:120] key_bitmap, [139:136] lever_switches,
    // [145:140] link_controls, [151:146] zero
    output logic [151:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rcfd_pkg::*;

    cfg_t          cfg;
    frame_t        frame;
    frame_status_t status;
    result_t       result;
    logic          s_fire;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_data_reg;

    assign pready        = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    rcfd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rcfd_frame_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s_fire),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser[0]),
        .link_format (s_axis_tuser[1]),
        .frame       (frame),
        .status      (status)
    );

    rcfd_unpack u_unpack (
        .frame  (frame),
        .fmt    (status.fmt),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        priority if (s_fire && status.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && status.last)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

`ifndef SYNTH
    // A result only appears after the last byte of a frame was accepted.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(s_fire && status.last))
        else $error("result register loaded without a completed frame");

    // In the receiver format the write position never passes the 18th byte.
    a_rx_position: assert property (@(posedge clk) disable iff (!rst_n)
        (!status.fmt && !s_axis_tuser[0]) |-> (status.pos <= RX_LAST_POS))
        else $error("receiver frame position out of range");

    // A stalled result is never overwritten by a new frame.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_fire)
        else $error("input accepted while a result is stalled");
`endif

endmodule

`default_nettype wire
